// ===== design/gaim_pkg.sv =====
// Shared types and constants for the Galois automorphism index map.
package gaim_pkg;

    // Field widths of the request, the result and the config register
    localparam int unsigned ROT_W     = 32;
    localparam int unsigned IDX_W     = 16;
    localparam int unsigned GE_W      = 17;
    localparam int unsigned LOG_N_W   = 5;

    // Ring size limits and register reset value
    localparam int unsigned LOG_N_MAX_DEF = 16;
    localparam int unsigned LOG_N_MIN     = 2;
    localparam int unsigned LOG_N_RESET   = 16;

    // Map modes
    localparam logic MODE_COEFF = 1'b0;
    localparam logic MODE_NTT   = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [ROT_W-1:0] rotation;
        logic [IDX_W-1:0]        coeff_index;
    } in_t;

    typedef struct packed {
        logic [GE_W-1:0]  galois_element;
        logic [IDX_W-1:0] dest_index;
        logic [IDX_W-1:0] source_index;
        logic             negate;
    } out_t;

endpackage

// ===== design/gaim_mulmod.sv =====
// Shared modular multiplier: product modulo 2N with registered output.
module gaim_mulmod #(
    parameter int unsigned W2N = gaim_pkg::LOG_N_MAX_DEF + 1
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W2N-1:0] mask2n,
    input  logic [W2N-1:0] op_a,
    input  logic [W2N-1:0] op_b,
    output logic [W2N-1:0] prod
);

    logic [2*W2N-1:0] full_prod;
    logic [W2N-1:0]   prod_reg;
    logic [W2N-1:0]   prod_next;

    // Multiply and reduce by the power-of-two modulus
    always_comb begin
        full_prod = op_a * op_b;
        prod_next = full_prod[W2N-1:0] & mask2n;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/gaim_ctrl.sv =====
// Sequencer for square-and-multiply, index mapping and the result register.
module gaim_ctrl #(
    parameter int unsigned LOG_N_MAX = gaim_pkg::LOG_N_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [gaim_pkg::LOG_N_W-1:0]    log_n_eff,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gaim_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gaim_pkg::out_t                  m_data
);

    localparam int unsigned LW  = LOG_N_MAX;
    localparam int unsigned W2N = LOG_N_MAX + 1;
    localparam int unsigned EW  = LOG_N_MAX - 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MR   = 5'b00010,
        S_SQ   = 5'b00100,
        S_MAP  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [W2N-1:0] base_reg, base_next;
    logic [W2N-1:0] res_reg, res_next;
    logic           first_reg, first_next;
    logic           mode_reg, mode_next;
    logic [LW-1:0]  idx_reg, idx_next;
    gaim_pkg::out_t out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic [LW-1:0]  mask_n;
    logic [W2N-1:0] mask2n;
    logic [EW-1:0]  slot_mask;
    logic [5:0]     rev_shift;
    logic [EW-1:0]  e_in;
    logic [EW-1:0]  e_shr;
    logic [W2N-1:0] base_cur;
    logic [W2N-1:0] odd;
    logic           mul_en;
    logic [W2N-1:0] op_a, op_b, prod;
    logic           load_out;
    logic [LW-1:0]  sn;
    logic [LW-1:0]  map_dest, map_src;
    logic           map_neg;

    // Reverse all 32 bits; the caller shifts the used bits down
    function automatic logic [31:0] bitrev32(input logic [31:0] v);
        logic [31:0] r;
        for (int b = 0; b < 32; b++) begin
            r[b] = v[31-b];
        end
        return r;
    endfunction

    // Masks for the current ring degree
    always_comb begin
        mask_n    = ~({LW{1'b1}} << log_n_eff);
        mask2n    = ~({W2N{1'b1}} << ({1'b0, log_n_eff} + 6'd1));
        slot_mask = ~({EW{1'b1}} << ({1'b0, log_n_eff} - 6'd1));
        rev_shift = 6'd32 - {1'b0, log_n_eff};
    end

    assign e_in     = EW'(s_data.rotation) & slot_mask;
    assign e_shr    = e_reg >> 1;
    assign base_cur = first_reg ? base_reg : prod;
    assign odd      = (W2N'(idx_reg) << 1) | W2N'(1);

    // Operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            S_MR: begin
                mul_en = 1'b1;
                op_a   = res_reg;
                op_b   = base_cur;
            end
            S_SQ: begin
                mul_en = 1'b1;
                op_a   = base_reg;
                op_b   = base_reg;
            end
            S_MAP: begin
                mul_en = 1'b1;
                op_a   = (mode_reg == gaim_pkg::MODE_NTT) ? odd : W2N'(idx_reg);
                op_b   = res_reg;
            end
            S_IDLE, S_FIN: begin
                mul_en = 1'b0;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    gaim_mulmod #(
        .W2N (W2N)
    ) u_mulmod (
        .aclk   (aclk),
        .en     (mul_en),
        .mask2n (mask2n),
        .op_a   (op_a),
        .op_b   (op_b),
        .prod   (prod)
    );

    // Index mapping from the final product
    always_comb begin
        sn = LW'(prod >> 1) & mask_n;
        if (mode_reg == gaim_pkg::MODE_NTT) begin
            map_dest = LW'(bitrev32(32'(idx_reg)) >> rev_shift);
            map_src  = LW'(bitrev32(32'(sn)) >> rev_shift);
            map_neg  = 1'b0;
        end else begin
            map_dest = LW'(prod) & mask_n;
            map_src  = idx_reg;
            map_neg  = |(prod >> log_n_eff);
        end
    end

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        e_next     = e_reg;
        base_next  = base_reg;
        res_next   = res_reg;
        first_next = first_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    e_next     = e_in;
                    base_next  = W2N'(5);
                    res_next   = W2N'(1);
                    first_next = 1'b1;
                    mode_next  = s_data.mode;
                    idx_next   = LW'(s_data.coeff_index) & mask_n;
                    state_next = (e_in == '0) ? S_MAP : S_MR;
                end
            end
            S_MR: begin
                base_next  = base_cur;
                first_next = 1'b0;
                state_next = S_SQ;
            end
            S_SQ: begin
                if (e_reg[0]) begin
                    res_next = prod;
                end
                e_next     = e_shr;
                state_next = (e_shr == '0) ? S_MAP : S_MR;
            end
            S_MAP: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb begin
        out_next                = out_reg;
        out_valid_next          = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_next.galois_element = gaim_pkg::GE_W'(res_reg);
            out_next.dest_index     = gaim_pkg::IDX_W'(map_dest);
            out_next.source_index   = gaim_pkg::IDX_W'(map_src);
            out_next.negate         = map_neg;
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg     <= e_next;
        base_reg  <= base_next;
        res_reg   <= res_next;
        first_reg <= first_next;
        mode_reg  <= mode_next;
        idx_reg   <= idx_next;
        out_reg   <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Busy right after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready high in cycle after accepted request");

    // Result register loads only out of the final state
    a_load_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside final state");

    // A power of five is always odd
    a_element_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_reg.galois_element[0])
        else $error("galois element is even");

    // Squaring only runs with exponent bits left
    a_exp_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SQ |-> e_reg != '0)
        else $error("square step with exhausted exponent");

endmodule

// ===== design/galois_automorphism_index_map_core.sv =====
// Top level of the Galois automorphism index map: config register and sequencer.
//
// Usage:
//   One request on s_valid/s_ready/s_data carries a mode, a signed slot rotation
//   and a coefficient index. One result leaves on m_valid/m_ready/m_data: the
//   Galois element 5^r mod 2N, destination and source indices, and a negate flag.
//   The ring degree is set by cfg_wr_en/cfg_wr_data (log2 N, clamped to
//   2..LOG_N_MAX); write it only while no request is in flight.
//   Sequence: with b the bit length of the reduced rotation (b <= log_n - 1),
//   the shared multiplier runs two products per exponent bit (multiply,
//   then square), then one mapping product; the result register loads in the
//   final state, and the next request is taken only once back in idle.
//   A single multiplier inside the sequencer serves all of these products.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls and a second result is finished, the
//   sequencer holds that result and takes no request until the register frees.
//   Reset: log_n returns to 16, no request is in flight, m_valid is low.
module galois_automorphism_index_map_core #(
    parameter int unsigned LOG_N_MAX = gaim_pkg::LOG_N_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gaim_pkg::LOG_N_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gaim_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gaim_pkg::out_t                m_data
);

    logic [gaim_pkg::LOG_N_W-1:0] log_n_reg, log_n_next;
    logic [gaim_pkg::LOG_N_W-1:0] log_n_eff;

    // Configuration register
    assign log_n_next = cfg_wr_en ? cfg_wr_data : log_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_n_reg <= gaim_pkg::LOG_N_W'(gaim_pkg::LOG_N_RESET);
        end else begin
            log_n_reg <= log_n_next;
        end
    end

    // Saturate to the supported range
    always_comb begin
        priority if (log_n_reg < gaim_pkg::LOG_N_W'(gaim_pkg::LOG_N_MIN)) begin
            log_n_eff = gaim_pkg::LOG_N_W'(gaim_pkg::LOG_N_MIN);
        end else if (log_n_reg > gaim_pkg::LOG_N_W'(LOG_N_MAX)) begin
            log_n_eff = gaim_pkg::LOG_N_W'(LOG_N_MAX);
        end else begin
            log_n_eff = log_n_reg;
        end
    end

    gaim_ctrl #(
        .LOG_N_MAX (LOG_N_MAX)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .log_n_eff (log_n_eff),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sim/tb.sv =====
// Testbench for the Galois automorphism index map core: scoreboard class and stimulus.
module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 57;
    localparam int NUM_PHASES     = 12;

    // Predicts index maps for accepted requests and checks results in order
    class gaim_scoreboard;
        logic [gaim_pkg::LOG_N_W-1:0] log_n_reg;
        gaim_pkg::out_t               expected_q[$];
        int                           errors;

        function new();
            log_n_reg = gaim_pkg::LOG_N_W'(gaim_pkg::LOG_N_RESET);
            errors    = 0;
        endfunction

        function void set_log_n(logic [gaim_pkg::LOG_N_W-1:0] value);
            log_n_reg = value;
        endfunction

        function longint unsigned rev_bits(longint unsigned v, int unsigned bits);
            longint unsigned r;
            r = 0;
            for (int unsigned b = 0; b < bits; b++) begin
                r = (r << 1) | (v & 64'd1);
                v = v >> 1;
            end
            return r;
        endfunction

        // Galois element by square and multiply, then the mode's index mapping
        function gaim_pkg::out_t map_index(gaim_pkg::in_t req);
            int unsigned     l;
            longint unsigned n, mask_n, mask2n, slot_mask;
            longint unsigned r, k, base, idx, m, odd, se, sn, dest, src, neg;
            gaim_pkg::out_t  res;
            l = log_n_reg;
            if (l < gaim_pkg::LOG_N_MIN) l = gaim_pkg::LOG_N_MIN;
            if (l > gaim_pkg::LOG_N_MAX_DEF) l = gaim_pkg::LOG_N_MAX_DEF;
            n         = 64'd1 << l;
            mask_n    = n - 1;
            mask2n    = (n << 1) - 1;
            slot_mask = (n >> 1) - 1;
            idx       = 64'(req.coeff_index) & mask_n;
            r         = 64'(req.rotation[gaim_pkg::ROT_W-1:0]) & slot_mask;
            k         = 1;
            base      = 5;
            while (r != 0) begin
                if (r[0]) k = (k * base) & mask2n;
                base = (base * base) & mask2n;
                r = r >> 1;
            end
            neg = 0;
            if (req.mode == gaim_pkg::MODE_COEFF) begin
                m = (idx * k) & mask2n;
                if (m >= n) begin
                    dest = m - n;
                    neg  = 1;
                end else begin
                    dest = m;
                end
                src = idx;
            end else begin
                odd  = (idx << 1) + 1;
                se   = (odd * k) & mask2n;
                sn   = ((se - 1) >> 1) & mask_n;
                dest = rev_bits(idx, l);
                src  = rev_bits(sn, l);
            end
            res.galois_element = k[gaim_pkg::GE_W-1:0];
            res.dest_index     = dest[gaim_pkg::IDX_W-1:0];
            res.source_index   = src[gaim_pkg::IDX_W-1:0];
            res.negate         = neg[0];
            return res;
        endfunction

        function void note_request(gaim_pkg::in_t req);
            expected_q.push_back(map_index(req));
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(gaim_pkg::out_t got);
            gaim_pkg::out_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: %h", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("galois_element", exp_r.galois_element, got.galois_element);
            compare_field("dest_index", exp_r.dest_index, got.dest_index);
            compare_field("source_index", exp_r.source_index, got.source_index);
            compare_field("negate", exp_r.negate, got.negate);
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [gaim_pkg::LOG_N_W-1:0] cfg_wr_data = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    gaim_pkg::in_t                s_data      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    gaim_pkg::out_t               m_data;

    int src_idle_pct = 17;
    int dst_idle_pct = 88;
    int quiet_cycles = 0;

    gaim_scoreboard sb = new();

    galois_automorphism_index_map_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Request monitor, result sink with random backpressure
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_data);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one request, with random gaps beforehand, and wait for accept
    task automatic send_request(logic mode, logic [gaim_pkg::ROT_W-1:0] rot,
                                logic [gaim_pkg::IDX_W-1:0] idx);
        gaim_pkg::in_t req;
        req.mode        = mode;
        req.rotation    = rot;
        req.coeff_index = idx;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_log_n(logic [gaim_pkg::LOG_N_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_log_n(value);
        @(posedge aclk);
    endtask

    function automatic logic [gaim_pkg::ROT_W-1:0] pick_rotation();
        unique case ($urandom_range(4))
            0: return $urandom();
            1: return gaim_pkg::ROT_W'($urandom_range(0, 70000));
            2: return -gaim_pkg::ROT_W'($urandom_range(1, 70000));
            3: return gaim_pkg::ROT_W'($urandom_range(0, 40));
            default: begin
                unique case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    logic [gaim_pkg::LOG_N_W-1:0] phase_log_n[NUM_PHASES] =
        '{5'd2, 5'd16, 5'd9, 5'd31, 5'd15, 5'd0, 5'd3, 5'd12, 5'd1, 5'd17, 5'd6, 5'd16};

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes at the reset ring size
        send_request(gaim_pkg::MODE_COEFF, 32'h0000_0000, 16'h0000);
        send_request(gaim_pkg::MODE_NTT,   32'h0000_0000, 16'h0000);
        send_request(gaim_pkg::MODE_COEFF, 32'h0000_0001, 16'h0001);
        send_request(gaim_pkg::MODE_NTT,   32'h0000_0001, 16'h0001);
        send_request(gaim_pkg::MODE_COEFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(gaim_pkg::MODE_NTT,   32'hFFFF_FFFF, 16'hFFFF);
        send_request(gaim_pkg::MODE_COEFF, 32'h0000_7FFF, 16'h8000);
        send_request(gaim_pkg::MODE_NTT,   32'h0000_7FFF, 16'h8000);
        send_request(gaim_pkg::MODE_COEFF, 32'h0000_8000, 16'h7FFF);
        send_request(gaim_pkg::MODE_NTT,   32'hFFFF_8000, 16'h1234);
        send_request(gaim_pkg::MODE_COEFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(gaim_pkg::MODE_NTT,   32'h8000_0000, 16'hFFFF);
        send_request(gaim_pkg::MODE_COEFF, 32'h8000_0000, 16'hAAAA);
        send_request(gaim_pkg::MODE_NTT,   32'h7FFF_FFFF, 16'h5555);
        drain();

        // Directed: ring sizes below the floor and above the ceiling, wide indices, negative rotations
        write_log_n(5'd0);
        send_request(gaim_pkg::MODE_COEFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(gaim_pkg::MODE_NTT,   32'hFFFF_FFFF, 16'hFFFF);
        send_request(gaim_pkg::MODE_COEFF, 32'h0000_0001, 16'h0003);
        send_request(gaim_pkg::MODE_NTT,   32'hFFFF_FFFE, 16'hFFFE);
        drain();
        write_log_n(5'd31);
        send_request(gaim_pkg::MODE_COEFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(gaim_pkg::MODE_NTT,   32'h0000_7FFF, 16'hFFFF);
        drain();

        // Random phases over ring sizes and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PHASES / 3) begin
                src_idle_pct = 17;
                dst_idle_pct = 88;
            end else if (p < 2 * NUM_PHASES / 3) begin
                src_idle_pct = 88;
                dst_idle_pct = 17;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            write_log_n(phase_log_n[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(logic'($urandom_range(1)), pick_rotation(),
                             gaim_pkg::IDX_W'($urandom()));
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gaim_pkg.sv
design/gaim_mulmod.sv
design/gaim_ctrl.sv
design/galois_automorphism_index_map_core.sv
sim/tb.sv
